// ===== src/lpms_pkg.sv =====
// Shared constants for the line pair midpoint similarity block.
package lpms_pkg;

  // Default fixed-point format of crossing coordinates (Q12.4).
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;

  // Fixed field widths.
  localparam int COEF_W  = 16;
  localparam int CONST_W = 32;
  localparam int DIST_W  = 36;
  localparam int LIMIT_W = 16;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_X_MIN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_MIN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_X_MAX = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_MAX = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT = 3'd4;

  // Reset values of the box and threshold registers.
  localparam int BOX_MAX_RST = 4095;
  localparam int LIMIT_RST   = 16;

  // Box sides in the order they are tested.
  localparam int NUM_SIDES   = 4;
  localparam int SIDE_TOP    = 0;
  localparam int SIDE_RIGHT  = 1;
  localparam int SIDE_BOTTOM = 2;
  localparam int SIDE_LEFT   = 3;

endpackage

// ===== src/lpms_in_if.sv =====
// Input channel carrying one pair of lines per transaction.
interface lpms_in_if;
  import lpms_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COEF_W-1:0]  first_a;
  logic signed [COEF_W-1:0]  first_b;
  logic signed [CONST_W-1:0] first_c;
  logic signed [COEF_W-1:0]  second_a;
  logic signed [COEF_W-1:0]  second_b;
  logic signed [CONST_W-1:0] second_c;

  modport source (output valid, first_a, first_b, first_c, second_a, second_b, second_c,
                  input ready);
  modport sink   (input valid, first_a, first_b, first_c, second_a, second_b, second_c,
                  output ready);
endinterface

// ===== src/lpms_out_if.sv =====
// Result channel carrying one similarity result per transaction.
interface lpms_out_if;
  import lpms_pkg::*;

  logic              valid;
  logic              ready;
  logic              similar;
  logic              both_clipped;
  logic [DIST_W-1:0] distance_sq;

  modport source (output valid, similar, both_clipped, distance_sq, input ready);
  modport sink   (input valid, similar, both_clipped, distance_sq, output ready);
endinterface

// ===== src/line_pair_midpoint_similarity_top.sv =====
// Line pair midpoint similarity: pipelined clip of two lines and midpoint distance.
//
//   Channel  | Direction | Handshake        | Contents
//   in_pair  | in        | valid / ready    | first_a/b/c, second_a/b/c
//   out_res  | out       | valid / ready    | similar, both_clipped, distance_sq
//   cfg_*    | in        | cfg_we only      | box edges and distance limit
//
// One transaction enters per cycle unless a stalled output has backed up every stage;
// the pipeline depth is set by the bit-per-stage quotient pipeline for the crossings.
// Reset is synchronous; it empties the pipeline and loads the register defaults.
// A stalled output holds its result; stages behind it keep filling bubbles
// and only stop once every stage holds a transaction.
module line_pair_midpoint_similarity_top #(
  parameter int COORD_BITS = lpms_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lpms_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lpms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lpms_pkg::CFG_DATA_W-1:0] cfg_data,
  lpms_in_if.sink                         in_pair,
  lpms_out_if.source                      out_res
);
  import lpms_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int QW   = C + F;
  localparam int PW   = C + COEF_W + 1;
  localparam int NW   = ((PW > CONST_W) ? PW : CONST_W) + 2;
  localparam int AW   = COEF_W + 1;
  localparam int LW   = C + AW;
  localparam int NQ   = QW + AW + 2;
  localparam int DQ   = AW + 1;
  localparam int SW   = QW + 1;
  localparam int XW   = QW + 2;
  localparam int SQW  = 2 * QW + 2;
  localparam int SUMW = SQW + 1;
  localparam int MW   = (SUMW > DIST_W) ? SUMW : DIST_W;
  localparam int TW   = 2 * LIMIT_W + 2;
  localparam int DIV0 = 3;
  localparam int NST  = QW + 6;

  typedef struct packed {
    logic signed [NW-1:0]     num;
    logic signed [COEF_W-1:0] den;
  } side_t;

  typedef struct packed {
    logic signed [NW-1:0] nn;
    logic [AW-1:0]        ad;
    logic [LW-1:0]        lop;
    logic [LW-1:0]        hip;
  } norm_t;

  typedef struct packed {
    logic [NQ-1:0] rem;
    logic [DQ-1:0] den2;
    logic [QW-1:0] quo;
    logic [QW-1:0] fix;
    logic          isy;
  } end_t;

  typedef struct packed {
    end_t [3:0] e;
    logic [1:0] clip;
  } div_t;

  // Box and threshold registers.
  logic [C-1:0]       x_min_r, y_min_r, x_max_r, y_max_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= '0;
      y_min_r <= '0;
      x_max_r <= C'(BOX_MAX_RST);
      y_max_r <= C'(BOX_MAX_RST);
      limit_r <= LIMIT_W'(LIMIT_RST);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_X_MIN: x_min_r <= cfg_data[C-1:0];
        CFG_Y_MIN: y_min_r <= cfg_data[C-1:0];
        CFG_X_MAX: x_max_r <= cfg_data[C-1:0];
        CFG_Y_MAX: y_max_r <= cfg_data[C-1:0];
        CFG_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-side bounds: the edge multiplied into the line, and the crossing range.
  logic [C-1:0] bnd_mul [NUM_SIDES];
  logic [C-1:0] bnd_lo  [NUM_SIDES];
  logic [C-1:0] bnd_hi  [NUM_SIDES];

  always_comb begin
    bnd_mul[SIDE_TOP]    = y_min_r;
    bnd_mul[SIDE_RIGHT]  = x_max_r;
    bnd_mul[SIDE_BOTTOM] = y_max_r;
    bnd_mul[SIDE_LEFT]   = x_min_r;
    bnd_lo[SIDE_TOP]     = x_min_r;
    bnd_lo[SIDE_RIGHT]   = y_min_r;
    bnd_lo[SIDE_BOTTOM]  = x_min_r;
    bnd_lo[SIDE_LEFT]    = y_min_r;
    bnd_hi[SIDE_TOP]     = x_max_r;
    bnd_hi[SIDE_RIGHT]   = y_max_r;
    bnd_hi[SIDE_BOTTOM]  = x_max_r;
    bnd_hi[SIDE_LEFT]    = y_max_r;
  end

  // Stage valids and advance enables; a stage moves when empty or when the next moves.
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  assign en[NST-1] = !v_r[NST-1] || out_res.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign in_pair.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_pair.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: numerator of each side crossing, -(coef * edge + c).
  logic signed [COEF_W-1:0]  ca [2];
  logic signed [COEF_W-1:0]  cb [2];
  logic signed [CONST_W-1:0] cc [2];
  logic signed [PW-1:0]      prod [2][NUM_SIDES];
  side_t                     s1_nxt [2][NUM_SIDES];
  side_t                     s1_r   [2][NUM_SIDES];

  assign ca[0] = in_pair.first_a;
  assign cb[0] = in_pair.first_b;
  assign cc[0] = in_pair.first_c;
  assign ca[1] = in_pair.second_a;
  assign cb[1] = in_pair.second_b;
  assign cc[1] = in_pair.second_c;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < NUM_SIDES; s++) begin
        if (s == SIDE_RIGHT || s == SIDE_LEFT) begin
          prod[l][s]       = ca[l] * $signed({1'b0, bnd_mul[s]});
          s1_nxt[l][s].den = cb[l];
        end else begin
          prod[l][s]       = cb[l] * $signed({1'b0, bnd_mul[s]});
          s1_nxt[l][s].den = ca[l];
        end
        s1_nxt[l][s].num = -(NW'(prod[l][s]) + NW'(cc[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: make the denominator positive and scale the bounds by it.
  norm_t s2_nxt [2][NUM_SIDES];
  norm_t s2_r   [2][NUM_SIDES];

  always_comb begin
    logic signed [AW-1:0] dse;
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < NUM_SIDES; s++) begin
        dse = AW'(s1_r[l][s].den);
        if (dse[AW-1]) begin
          s2_nxt[l][s].ad = $unsigned(-dse);
          s2_nxt[l][s].nn = -s1_r[l][s].num;
        end else begin
          s2_nxt[l][s].ad = $unsigned(dse);
          s2_nxt[l][s].nn = s1_r[l][s].num;
        end
        s2_nxt[l][s].lop = bnd_lo[s] * s2_nxt[l][s].ad;
        s2_nxt[l][s].hip = bnd_hi[s] * s2_nxt[l][s].ad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: exact hit tests, pick the first two hit sides, set up the quotients.
  // A side parallel to the line has a zero denominator, so both bounds are zero
  // and the range test fails by itself.
  div_t div_r [0:QW];
  div_t d0_nxt;

  always_comb begin
    logic [3:0]           hit;
    logic [2:0]           cnt;
    logic [1:0]           sel0, sel1, sel;
    logic signed [NW-1:0] lo_c, hi_c, nn;
    logic [NQ-1:0]        nq  [NUM_SIDES];
    logic [QW-1:0]        fix [NUM_SIDES];
    d0_nxt = '0;
    for (int l = 0; l < 2; l++) begin
      cnt  = '0;
      sel0 = '0;
      sel1 = '0;
      for (int s = 0; s < NUM_SIDES; s++) begin
        nn   = s2_r[l][s].nn;
        lo_c = $signed(NW'(s2_r[l][s].lop));
        hi_c = $signed(NW'(s2_r[l][s].hip));
        if (s == SIDE_TOP || s == SIDE_RIGHT) begin
          hit[s] = !nn[NW-1] && (nn >= lo_c) && (nn < hi_c);
        end else begin
          hit[s] = !nn[NW-1] && (nn > lo_c) && (nn <= hi_c);
        end
        nq[s]  = (NQ'($unsigned(nn)) << (F + 1)) + NQ'(s2_r[l][s].ad);
        fix[s] = QW'(bnd_mul[s]) << F;
        if (hit[s]) begin
          if (cnt == 3'd0) begin
            sel0 = 2'(s);
          end else if (cnt == 3'd1) begin
            sel1 = 2'(s);
          end
          cnt = cnt + 3'd1;
        end
      end
      d0_nxt.clip[l] = (cnt >= 3'd2);
      for (int e = 0; e < 2; e++) begin
        sel = (e == 0) ? sel0 : sel1;
        d0_nxt.e[2*l+e].rem  = nq[sel];
        d0_nxt.e[2*l+e].den2 = {s2_r[l][sel].ad, 1'b0};
        d0_nxt.e[2*l+e].quo  = '0;
        d0_nxt.e[2*l+e].fix  = fix[sel];
        d0_nxt.e[2*l+e].isy  = sel[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      div_r[0] <= d0_nxt;
    end
  end

  // Quotient pipeline: one rounded-quotient bit per stage, most significant first.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    div_t div_nxt;

    always_comb begin
      logic [NQ-1:0] dsh;
      div_nxt = div_r[j];
      for (int e = 0; e < 4; e++) begin
        dsh = NQ'(div_r[j].e[e].den2) << B;
        if (div_r[j].e[e].rem >= dsh) begin
          div_nxt.e[e].rem    = div_r[j].e[e].rem - dsh;
          div_nxt.e[e].quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[DIV0+j]) begin
        div_r[j+1] <= div_nxt;
      end
    end
  end

  // Stage A: end-point sums per line and their differences.
  logic signed [XW-1:0] dx_r, dy_r;
  logic                 both_a_r;
  logic signed [XW-1:0] dx_nxt, dy_nxt;
  logic                 both_a_nxt;

  always_comb begin
    logic [SW-1:0] sx [2];
    logic [SW-1:0] sy [2];
    logic [QW-1:0] xa, xb, ya, yb;
    for (int l = 0; l < 2; l++) begin
      xa = div_r[QW].e[2*l].isy   ? div_r[QW].e[2*l].fix   : div_r[QW].e[2*l].quo;
      ya = div_r[QW].e[2*l].isy   ? div_r[QW].e[2*l].quo   : div_r[QW].e[2*l].fix;
      xb = div_r[QW].e[2*l+1].isy ? div_r[QW].e[2*l+1].fix : div_r[QW].e[2*l+1].quo;
      yb = div_r[QW].e[2*l+1].isy ? div_r[QW].e[2*l+1].quo : div_r[QW].e[2*l+1].fix;
      sx[l] = SW'(xa) + SW'(xb);
      sy[l] = SW'(ya) + SW'(yb);
    end
    dx_nxt     = $signed({1'b0, sx[0]}) - $signed({1'b0, sx[1]});
    dy_nxt     = $signed({1'b0, sy[0]}) - $signed({1'b0, sy[1]});
    both_a_nxt = &div_r[QW].clip;
  end

  always_ff @(posedge clk) begin
    if (en[QW+3]) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      both_a_r <= both_a_nxt;
    end
  end

  // Stage B: squares of the differences and the squared threshold.
  logic [SQW-1:0]           sqx_r, sqy_r;
  logic [TW-1:0]            thr_r;
  logic                     both_b_r;
  logic signed [2*XW-1:0]   sqx_full, sqy_full;
  logic [2*LIMIT_W-1:0]     lsq;

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;
  assign lsq      = limit_r * limit_r;

  always_ff @(posedge clk) begin
    if (en[QW+4]) begin
      sqx_r    <= sqx_full[SQW-1:0];
      sqy_r    <= sqy_full[SQW-1:0];
      thr_r    <= {lsq, 2'b00};
      both_b_r <= both_a_r;
    end
  end

  // Stage C: sum, saturate and compare into the output register.
  logic [MW-1:0]     dsum;
  logic              sim_nxt;
  logic [DIST_W-1:0] dist_nxt;
  logic              sim_r, both_r;
  logic [DIST_W-1:0] dist_r;

  assign dsum    = MW'(sqx_r) + MW'(sqy_r);
  assign sim_nxt = both_b_r && (dsum < MW'(thr_r));

  always_comb begin
    if (!both_b_r || dsum > MW'({DIST_W{1'b1}})) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = DIST_W'(dsum);
    end
  end

  always_ff @(posedge clk) begin
    if (en[QW+5]) begin
      sim_r  <= sim_nxt;
      both_r <= both_b_r;
      dist_r <= dist_nxt;
    end
  end

  assign out_res.valid        = v_r[NST-1];
  assign out_res.similar      = sim_r;
  assign out_res.both_clipped = both_r;
  assign out_res.distance_sq  = dist_r;

endmodule

// ===== src/lpms_checker.sv =====
// Port-level checker for the line pair midpoint similarity block, with its bind.
module lpms_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          similar,
  input logic                          both_clipped,
  input logic [lpms_pkg::DIST_W-1:0]   distance_sq
);
  import lpms_pkg::*;

  // A waiting result stays valid and keeps its distance until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(distance_sq))
    else $error("result changed while stalled");

  // A pair that does not clip reports the saturated distance and no similarity.
  a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !both_clipped |-> (distance_sq == '1) && !similar)
    else $error("unclipped pair with a real distance");

  // Similarity needs a distance below the largest possible squared threshold.
  a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && similar |-> (distance_sq >> (2 * LIMIT_W + 2)) == '0)
    else $error("similar flagged at a distance beyond any threshold");

  // An empty output stage never holds back the input.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind line_pair_midpoint_similarity_top lpms_checker u_lpms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_pair.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .similar      (out_res.similar),
  .both_clipped (out_res.both_clipped),
  .distance_sq  (out_res.distance_sq)
);
